// ----- rtl/ovle_pkg.sv -----
// shared constants and request and status codes of the ordered value list engine
package ovle_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int WORD_W = 32;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_DELETE  = 2'd1;
	localparam logic [1:0] REQ_REVERSE = 2'd2;
	localparam logic [1:0] REQ_READOUT = 2'd3;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

endpackage

// ----- rtl/ordered_value_list_engine.sv -----
// ordered value list engine: bounded list store with insert, delete, reverse and readout
// insert and delete search the entries, then move the ones behind the hit; reverse swaps
// pairs from both ends inward; readout gives one result per cycle. one request at a time,
// busy is high until the last result; the single store port (one read, one write per cycle)
// sets the pace of each request.
// reset empties the list; store contents are not cleared. the receiver cannot stall.
module ordered_value_list_engine #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           req_type,
	input  logic signed [ovle_pkg::WORD_W-1:0]   match_key,
	input  logic signed [ovle_pkg::WORD_W-1:0]   new_value,
	output logic                                 result_valid,
	output logic signed [ovle_pkg::WORD_W-1:0]   item_value,
	output logic                                 has_value,
	output logic [1:0]                           status,
	output logic                                 last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = ovle_pkg::WORD_W;
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_INS_SHIFT,
		ST_DEL_SHIFT,
		ST_REV_RLO,
		ST_REV_RHI,
		ST_REV_WLO,
		ST_REV_WHI,
		ST_READ
	} state_t;

	state_t          state_q;
	logic [1:0]      req_q;
	logic [DW-1:0]   key_q;
	logic [DW-1:0]   val_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [AW-1:0]   addr_s1;
	logic            pend_s1;
	logic [DW-1:0]   tmp_q;
	logic [DW-1:0]   rdata_q;
	logic [DW-1:0]   mem_q [CAPACITY];

	logic            result_valid_q;
	logic [DW-1:0]   item_value_q;
	logic            has_value_q;
	logic [1:0]      status_q;
	logic            last_q;

	logic            rd_en;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [DW-1:0]   wdata;
	logic            hit;
	logic            more;
	logic [CW-1:0]   hi_m1;

	assign hit   = pend_s1 && (rdata_q == key_q);
	assign more  = idx_q < count_q;
	assign hi_m1 = hi_q - ONE_C;
	assign busy  = (state_q != ST_IDLE);

	assign result_valid = result_valid_q;
	assign item_value   = item_value_q;
	assign has_value    = has_value_q;
	assign status       = status_q;
	assign last         = last_q;

	// store port control
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			ST_SRCH, ST_READ: begin
				rd_en = more;
				raddr = idx_q[AW-1:0];
			end
			ST_INS_SHIFT: begin
				rd_en = (rem_q != '0);
				raddr = idx_q[AW-1:0];
				if (pend_s1) begin
					we    = 1'b1;
					waddr = AW'(addr_s1 + AW'(1));
					wdata = rdata_q;
				end else if (rem_q == '0) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = val_q;
				end
			end
			ST_DEL_SHIFT: begin
				rd_en = (rem_q != '0);
				raddr = idx_q[AW-1:0];
				if (pend_s1) begin
					we    = 1'b1;
					waddr = AW'(addr_s1 - AW'(1));
					wdata = rdata_q;
				end
			end
			ST_REV_RLO: begin
				rd_en = (hi_q > CW'(lo_q + ONE_C));
				raddr = lo_q[AW-1:0];
			end
			ST_REV_RHI: begin
				rd_en = 1'b1;
				raddr = hi_m1[AW-1:0];
			end
			ST_REV_WLO: begin
				we    = 1'b1;
				waddr = lo_q[AW-1:0];
				wdata = rdata_q;
			end
			ST_REV_WHI: begin
				we    = 1'b1;
				waddr = hi_m1[AW-1:0];
				wdata = tmp_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			req_q          <= ovle_pkg::REQ_INSERT;
			key_q          <= '0;
			val_q          <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			rem_q          <= '0;
			pos_q          <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			addr_s1        <= '0;
			pend_s1        <= 1'b0;
			tmp_q          <= '0;
			result_valid_q <= 1'b0;
			item_value_q   <= '0;
			has_value_q    <= 1'b0;
			status_q       <= ovle_pkg::STAT_DONE;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req_type;
						key_q   <= match_key;
						val_q   <= new_value;
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						lo_q    <= '0;
						hi_q    <= count_q;
						case (req_type)
							ovle_pkg::REQ_INSERT: begin
								if (count_q == CAP_C) begin
									result_valid_q <= 1'b1;
									item_value_q   <= '0;
									has_value_q    <= 1'b0;
									status_q       <= ovle_pkg::STAT_FULL;
									last_q         <= 1'b1;
								end else begin
									state_q <= ST_SRCH;
								end
							end
							ovle_pkg::REQ_DELETE: begin
								state_q <= ST_SRCH;
							end
							ovle_pkg::REQ_REVERSE: begin
								state_q <= ST_REV_RLO;
							end
							default: begin
								if (count_q == '0) begin
									result_valid_q <= 1'b1;
									item_value_q   <= '0;
									has_value_q    <= 1'b0;
									status_q       <= ovle_pkg::STAT_DONE;
									last_q         <= 1'b1;
								end else begin
									state_q <= ST_READ;
								end
							end
						endcase
					end
				end
				ST_SRCH: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						if (req_q == ovle_pkg::REQ_INSERT) begin
							pos_q   <= CW'(addr_s1) + ONE_C;
							rem_q   <= count_q - (CW'(addr_s1) + ONE_C);
							idx_q   <= count_q - ONE_C;
							state_q <= ST_INS_SHIFT;
						end else begin
							rem_q   <= count_q - ONE_C - CW'(addr_s1);
							idx_q   <= CW'(addr_s1) + ONE_C;
							state_q <= ST_DEL_SHIFT;
						end
					end else if (!pend_s1 && !more) begin
						// no entry matched
						if (req_q == ovle_pkg::REQ_INSERT) begin
							pos_q   <= count_q;
							rem_q   <= '0;
							state_q <= ST_INS_SHIFT;
						end else begin
							result_valid_q <= 1'b1;
							item_value_q   <= '0;
							has_value_q    <= 1'b0;
							status_q       <= ovle_pkg::STAT_MISS;
							last_q         <= 1'b1;
							state_q        <= ST_IDLE;
						end
					end else begin
						pend_s1 <= more;
						addr_s1 <= idx_q[AW-1:0];
						if (more) begin
							idx_q <= idx_q + ONE_C;
						end
					end
				end
				ST_INS_SHIFT: begin
					// move entries up one place, top first
					pend_s1 <= (rem_q != '0);
					addr_s1 <= idx_q[AW-1:0];
					if (rem_q != '0) begin
						rem_q <= rem_q - ONE_C;
						idx_q <= idx_q - ONE_C;
					end else if (!pend_s1) begin
						count_q        <= count_q + ONE_C;
						result_valid_q <= 1'b1;
						item_value_q   <= '0;
						has_value_q    <= 1'b0;
						status_q       <= ovle_pkg::STAT_DONE;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_DEL_SHIFT: begin
					// move entries down one place over the hit
					pend_s1 <= (rem_q != '0);
					addr_s1 <= idx_q[AW-1:0];
					if (rem_q != '0) begin
						rem_q <= rem_q - ONE_C;
						idx_q <= idx_q + ONE_C;
					end else if (!pend_s1) begin
						count_q        <= count_q - ONE_C;
						result_valid_q <= 1'b1;
						item_value_q   <= '0;
						has_value_q    <= 1'b0;
						status_q       <= ovle_pkg::STAT_DONE;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_REV_RLO: begin
					if (hi_q > CW'(lo_q + ONE_C)) begin
						state_q <= ST_REV_RHI;
					end else begin
						result_valid_q <= 1'b1;
						item_value_q   <= '0;
						has_value_q    <= 1'b0;
						status_q       <= ovle_pkg::STAT_DONE;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_REV_RHI: begin
					tmp_q   <= rdata_q;
					state_q <= ST_REV_WLO;
				end
				ST_REV_WLO: begin
					state_q <= ST_REV_WHI;
				end
				ST_REV_WHI: begin
					lo_q    <= lo_q + ONE_C;
					hi_q    <= hi_q - ONE_C;
					state_q <= ST_REV_RLO;
				end
				ST_READ: begin
					// the read of the last entry leaves more low, so pend_s1 clears by itself
					pend_s1 <= more;
					addr_s1 <= idx_q[AW-1:0];
					if (more) begin
						idx_q <= idx_q + ONE_C;
					end
					if (pend_s1) begin
						result_valid_q <= 1'b1;
						item_value_q   <= rdata_q;
						has_value_q    <= 1'b1;
						status_q       <= ovle_pkg::STAT_DONE;
						last_q         <= (CW'(addr_s1) + ONE_C == count_q);
						if (CW'(addr_s1) + ONE_C == count_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- test/tb_ordered_value_list_engine.sv -----
// self-checking testbench for the ordered value list engine: directed table, then random requests
`timescale 1ns / 1ps

module tb_ordered_value_list_engine;

	localparam int DEPTH = ovle_pkg::CAPACITY_DEF;
	localparam int WW = ovle_pkg::WORD_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIRECTED_ROWS = 16;
	localparam int RANDOM_PER_PHASE = 21;

	typedef struct packed {
		logic [WW-1:0]     value;
		logic              has_value;
		logic [1:0]        status;
		logic              last;
	} list_result_t;

	typedef struct packed {
		logic [1:0]        req;
		logic [WW-1:0]     key;
		logic [WW-1:0]     val;
		logic [3:0]        reps;
		logic              typed;
		logic [1:0]        typed_status;
	} stim_row_t;

	// typed rows carry their one result; reps repeat a row with the value counting up
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ovle_pkg::REQ_READOUT, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b1, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_DELETE,  32'h0000_0000, 32'h0000_0000, 4'd1,  1'b1, ovle_pkg::STAT_MISS},
		'{ovle_pkg::REQ_INSERT,  32'h0000_0000, 32'h8000_0000, 4'd1,  1'b1, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_INSERT,  32'h8000_0000, 32'h7FFF_FFFF, 4'd1,  1'b1, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_INSERT,  32'h8000_0000, 32'hFFFF_FFFF, 4'd1,  1'b1, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_REVERSE, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b1, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_READOUT, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_INSERT,  32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_DELETE,  32'h0000_0001, 32'h0000_0000, 4'd1,  1'b1, ovle_pkg::STAT_MISS},
		'{ovle_pkg::REQ_INSERT,  32'h5555_5555, 32'hAAAA_AAA0, 4'd11, 1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_INSERT,  32'h0000_0000, 32'h1234_5678, 4'd1,  1'b1, ovle_pkg::STAT_FULL},
		'{ovle_pkg::REQ_READOUT, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_REVERSE, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_DELETE,  32'h7FFF_FFFF, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE},
		'{ovle_pkg::REQ_READOUT, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, ovle_pkg::STAT_DONE}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               req_type;
	logic signed [WW-1:0]     match_key;
	logic signed [WW-1:0]     new_value;
	logic                     result_valid;
	logic signed [WW-1:0]     item_value;
	logic                     has_value;
	logic [1:0]               status;
	logic                     last;

	logic [WW-1:0]     shadow_list [DEPTH];
	int                shadow_count;
	list_result_t      pending_results [$];
	int                error_count = 0;
	int                idle_cycles = 0;

	ordered_value_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.match_key(match_key),
		.new_value(new_value),
		.result_valid(result_valid),
		.item_value(item_value),
		.has_value(has_value),
		.status(status),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// updates the shadow list for one request and, when record is set, queues the results it gives
	task automatic apply_request(input logic [1:0] req, input logic [WW-1:0] key,
			input logic [WW-1:0] val, input bit record);
		int hit;
		int pos;
		logic [WW-1:0] swap;
		list_result_t res;
		hit = -1;
		res = {32'd0, 1'b0, ovle_pkg::STAT_DONE, 1'b1};
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_list[i] === key)
				hit = i;
		case (req)
			ovle_pkg::REQ_INSERT: begin
				if (shadow_count >= DEPTH) begin
					res.status = ovle_pkg::STAT_FULL;
				end else begin
					pos = (hit < 0) ? shadow_count : hit + 1;
					for (int i = shadow_count; i > pos; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[pos] = val;
					shadow_count++;
				end
			end
			ovle_pkg::REQ_DELETE: begin
				if (hit < 0) begin
					res.status = ovle_pkg::STAT_MISS;
				end else begin
					for (int i = hit; i + 1 < shadow_count; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_count--;
				end
			end
			ovle_pkg::REQ_REVERSE: begin
				for (int i = 0; i < shadow_count / 2; i++) begin
					swap = shadow_list[i];
					shadow_list[i] = shadow_list[shadow_count - 1 - i];
					shadow_list[shadow_count - 1 - i] = swap;
				end
			end
			default: begin
				// readout of a non-empty list gives one result per entry
				if (shadow_count > 0) begin
					if (record)
						for (int i = 0; i < shadow_count; i++)
							pending_results.push_back({shadow_list[i], 1'b1,
								ovle_pkg::STAT_DONE,
								(i == shadow_count - 1) ? 1'b1 : 1'b0});
					return;
				end
			end
		endcase
		if (record)
			pending_results.push_back(res);
	endtask

	task automatic send_request(input logic [1:0] req, input logic [WW-1:0] key,
			input logic [WW-1:0] val, input int idle_pct, input bit typed,
			input logic [1:0] typed_status);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		match_key <= key;
		new_value <= val;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_request(req, key, val, !typed);
		if (typed)
			pending_results.push_back({32'd0, 1'b0, typed_status, 1'b1});
	endtask

	// holds the sender off until every queued result has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	// values that make duplicates and boundary matches likely
	function automatic logic [WW-1:0] common_value();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			2: return 32'h0000_0001;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			default: return 32'h0000_0002;
		endcase
	endfunction

	task automatic send_random(input int idx, input int idle_pct);
		int pick;
		int ins_w;
		logic [1:0] req;
		logic [WW-1:0] key;
		logic [WW-1:0] val;
		// alternate growing and shrinking stretches so both full and empty come up
		ins_w = ((idx / 14) % 2 == 0) ? 55 : 15;
		pick = $urandom_range(99);
		if (pick < ins_w)
			req = ovle_pkg::REQ_INSERT;
		else if (pick < 70)
			req = ovle_pkg::REQ_DELETE;
		else if (pick < 80)
			req = ovle_pkg::REQ_REVERSE;
		else
			req = ovle_pkg::REQ_READOUT;
		pick = $urandom_range(99);
		if (pick < 65 && shadow_count > 0)
			key = shadow_list[$urandom_range(shadow_count - 1)];
		else if (pick < 85)
			key = common_value();
		else
			key = $urandom;
		pick = $urandom_range(99);
		if (pick < 40)
			val = $urandom;
		else if (pick < 75)
			val = common_value();
		else
			val = $urandom_range(7) - 3;
		send_request(req, key, val, idle_pct, 1'b0, ovle_pkg::STAT_DONE);
	endtask

	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none,", $time);
				$display("%0t:   actual value %h has %b status %0d last %b",
					$time, item_value, has_value, status, last);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (item_value !== exp_res.value || has_value !== exp_res.has_value ||
						status !== exp_res.status || last !== exp_res.last) begin
					$display("%0t: result mismatch: expected value %h has %b status %0d last %b",
						$time, exp_res.value, exp_res.has_value, exp_res.status, exp_res.last);
					$display("%0t:                  actual   value %h has %b status %0d last %b",
						$time, item_value, has_value, status, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_ordered_value_list_engine NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int phase_idle [4];
		arst_n = 1'b0;
		start = 1'b0;
		req_type = ovle_pkg::REQ_INSERT;
		match_key = '0;
		new_value = '0;
		shadow_count = 0;
		phase_idle = '{0, 72, 28, 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			for (int k = 0; k < DIRECTED[r].reps; k++)
				send_request(DIRECTED[r].req, DIRECTED[r].key, DIRECTED[r].val + k, 0,
					DIRECTED[r].typed, DIRECTED[r].typed_status);

		for (int p = 0; p < 4; p++) begin
			if (p == 1)
				wait_drained();
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_random(p * RANDOM_PER_PHASE + n, phase_idle[p]);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_ordered_value_list_engine OK");
		else
			$display("tb_ordered_value_list_engine NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ovle_pkg.sv
rtl/ordered_value_list_engine.sv
test/tb_ordered_value_list_engine.sv
